### src/mfbp_pkg.sv
// Shared types and constants for the MSB-first bit packer.
// Used by every module in src; depends on nothing.
package mfbp_pkg;

    // Operation codes carried on the func field.
    localparam int          FUNC_W    = 3;
    localparam logic [2:0]  FUNC_BIT   = 3'd0;
    localparam logic [2:0]  FUNC_U8    = 3'd1;
    localparam logic [2:0]  FUNC_U16   = 3'd2;
    localparam logic [2:0]  FUNC_U32   = 3'd3;
    localparam logic [2:0]  FUNC_FLUSH = 3'd4;

    localparam int VALUE_W     = 32;
    localparam int BYTES_MAX   = 4;
    localparam int IDX_W       = $clog2(BYTES_MAX);
    localparam int QUEUE_DEPTH = 2;

    // One queued item: the bytes it produces and the index of its final byte.
    typedef struct packed {
        logic [BYTES_MAX-1:0][7:0] bytes;
        logic [IDX_W-1:0]          last_idx;
    } t_entry;

    // Queue occupancy flags seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

### src/msb_first_bit_packer.sv
// Path: an accepted item is written into the queue, then loaded into the output byte
// register, from which its bytes are offered on the output.
// Throughput: one item per cycle while the output is not stalled and each item yields at
// most one byte; the single output byte register sends one byte per cycle while not stalled,
// holding a 16-bit write for two bytes and a 32-bit write for four; the queue absorbs the rest.
// Reset: synchronous, active low; clears the partial byte, the offset and the queue.
// Top level of the MSB-first bit packer; depends on mfbp_pkg, mfbp_front, mfbp_queue, mfbp_back.
module msb_first_bit_packer #(
    parameter int QUEUE_DEPTH = mfbp_pkg::QUEUE_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [mfbp_pkg::FUNC_W-1:0]  i_func,
    input  logic [mfbp_pkg::VALUE_W-1:0] i_value,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [7:0]                   o_out_byte,
    output logic                         o_last
);

    mfbp_pkg::t_q_status w_q_status;
    mfbp_pkg::t_entry    w_push_entry;
    mfbp_pkg::t_entry    w_pop_entry;
    logic                w_push;
    logic                w_pop;

    // Front end: accepts items and computes their bytes.
    mfbp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_func     (i_func),
        .i_value    (i_value),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_entry    (w_push_entry)
    );

    // Queue between the two ends.
    mfbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_entry  (w_push_entry),
        .i_pop    (w_pop),
        .o_entry  (w_pop_entry),
        .o_status (w_q_status)
    );

    // Back end: sends bytes one at a time.
    mfbp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_entry    (w_pop_entry),
        .i_q_status (w_q_status),
        .o_pop      (w_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

endmodule

### src/mfbp_front.sv
// Front end of the bit packer: accepts items, updates the partial byte state
// and pushes the bytes each item produces. Depends on mfbp_pkg.
module mfbp_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [mfbp_pkg::FUNC_W-1:0]  i_func,
    input  logic [mfbp_pkg::VALUE_W-1:0] i_value,
    input  mfbp_pkg::t_q_status          i_q_status,
    output logic                         o_push,
    output mfbp_pkg::t_entry             o_entry
);

    logic [7:0] r_pend;
    logic [7:0] n_pend;
    logic [2:0] r_off;
    logic [2:0] n_off;

    logic [mfbp_pkg::BYTES_MAX-1:0][7:0] w_vin;
    logic [7:0]                          w_carry [0:mfbp_pkg::BYTES_MAX];
    logic [15:0]                         w_sh    [0:mfbp_pkg::BYTES_MAX-1];
    logic [mfbp_pkg::BYTES_MAX-1:0][7:0] w_out;
    logic [7:0]                          w_bit_pend;
    logic                                w_push;
    logic                                w_accept;
    mfbp_pkg::t_entry                    w_entry;

    assign w_vin    = i_value;
    assign w_accept = i_valid && !i_q_status.full;
    assign o_stall  = i_q_status.full;
    assign o_push   = w_accept && w_push;
    assign o_entry  = w_entry;

    // Unaligned byte writes: each byte is split across the current offset,
    // its high part completing the pending byte and its low part carried on.
    always_comb begin
        w_carry[0] = r_pend;
        for (int k = 0; k < mfbp_pkg::BYTES_MAX; k++) begin
            w_sh[k]      = {w_vin[k], 8'h00} >> r_off;
            w_out[k]     = w_carry[k] | w_sh[k][15:8];
            w_carry[k+1] = w_sh[k][7:0];
        end
    end

    // The single bit lands at position seven minus the offset.
    assign w_bit_pend = r_pend | (i_value[0] ? (8'h80 >> r_off) : 8'h00);

    // Decode the operation into a queue entry and the next state.
    always_comb begin
        n_pend           = r_pend;
        n_off            = r_off;
        w_push           = 1'b0;
        w_entry.bytes    = w_out;
        w_entry.last_idx = '0;
        unique case (i_func)
            mfbp_pkg::FUNC_BIT: begin
                n_off = r_off + 3'd1;
                if (r_off == 3'd7) begin
                    w_push           = 1'b1;
                    w_entry.bytes[0] = w_bit_pend;
                    n_pend           = 8'h00;
                end else begin
                    n_pend = w_bit_pend;
                end
            end
            mfbp_pkg::FUNC_U8: begin
                w_push = 1'b1;
                n_pend = w_carry[1];
            end
            mfbp_pkg::FUNC_U16: begin
                w_push           = 1'b1;
                w_entry.last_idx = mfbp_pkg::IDX_W'(1);
                n_pend           = w_carry[2];
            end
            mfbp_pkg::FUNC_U32: begin
                w_push           = 1'b1;
                w_entry.last_idx = mfbp_pkg::IDX_W'(mfbp_pkg::BYTES_MAX - 1);
                n_pend           = w_carry[mfbp_pkg::BYTES_MAX];
            end
            mfbp_pkg::FUNC_FLUSH: begin
                if (r_off != 3'd0) begin
                    w_push           = 1'b1;
                    w_entry.bytes[0] = r_pend;
                    n_pend           = 8'h00;
                    n_off            = 3'd0;
                end
            end
            default: begin
                // Unused codes leave the state alone.
            end
        endcase
    end

    // Partial byte state advances only on an accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 8'h00;
            r_off  <= 3'd0;
        end else if (w_accept) begin
            r_pend <= n_pend;
            r_off  <= n_off;
        end
    end

endmodule

### src/mfbp_queue.sv
// Short FIFO of byte groups between the front and back ends of the packer.
// Depends on mfbp_pkg.
module mfbp_queue #(
    parameter int DEPTH = mfbp_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  mfbp_pkg::t_entry    i_entry,
    input  logic                i_pop,
    output mfbp_pkg::t_entry    o_entry,
    output mfbp_pkg::t_q_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mfbp_pkg::t_entry r_mem [0:DEPTH-1];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_entry         = r_mem[r_rd_ptr];
    assign o_status.full   = (r_count == CNT_W'(DEPTH));
    assign o_status.empty  = (r_count == '0);

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers wrap at the depth; the count tracks occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !i_pop && r_count == CNT_W'(DEPTH)))
        else $error("queue pushed while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && r_count == '0))
        else $error("queue popped while empty");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not follow a push");
`endif

endmodule

### src/mfbp_back.sv
// Back end of the bit packer: takes byte groups from the queue and sends
// them one byte per cycle while the output is not stalled, marking the final byte of each item.
// Depends on mfbp_pkg.
module mfbp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mfbp_pkg::t_entry    i_entry,
    input  mfbp_pkg::t_q_status i_q_status,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [7:0]          o_out_byte,
    output logic                o_last
);

    logic                       r_valid;
    mfbp_pkg::t_entry           r_entry;
    logic [mfbp_pkg::IDX_W-1:0] r_idx;
    logic                       w_fire;
    logic                       w_done;

    assign w_fire     = r_valid && !i_stall;
    assign o_last     = (r_idx == r_entry.last_idx);
    assign w_done     = w_fire && o_last;
    assign o_pop      = !i_q_status.empty && (!r_valid || w_done);
    assign o_valid    = r_valid;
    assign o_out_byte = r_entry.bytes[r_idx];

    // Control: a new group loads when none is held or the current one has sent its final byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (w_done) begin
            r_valid <= 1'b0;
        end else if (w_fire) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // Payload register.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_entry <= i_entry;
        end
    end

`ifndef SYNTH
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_idx <= r_entry.last_idx))
        else $error("byte index passed the final byte");
    a_load_starts_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_valid && r_idx == '0))
        else $error("loaded group does not start at its first byte");
    a_stalled_byte_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out_byte) && $stable(o_last)))
        else $error("stalled output byte changed");
`endif

endmodule
